[rtl/core/md5_digest_engine_top_defines.svh]
// Assertion macros used by the MD5 digest engine top level.
`ifndef MD5_DIGEST_ENGINE_TOP_DEFINES_SVH
`define MD5_DIGEST_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MD5_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MD5_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/md5_pkg.sv]
// Shared types, constants and helper functions of the MD5 digest engine.
package md5_pkg;

   // Initial chaining words
   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hEFCDAB89;
   localparam logic [31:0] INIT_C = 32'h98BADCFE;
   localparam logic [31:0] INIT_D = 32'h10325476;

   localparam logic [31:0] PAD_BYTE = 32'h0000_0080;
   localparam logic [3:0]  LEN_LO_SLOT = 4'd14;
   localparam logic [3:0]  LAST_SLOT = 4'd15;
   localparam logic [5:0]  LAST_ROUND = 6'd63;
   localparam logic [2:0]  FULL_WORD_BYTES = 3'd4;
   localparam logic [63:0] FULL_WORD_BITS = 64'd32;

   // Per-round additive constants
   localparam logic [31:0] SINE_ADD [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Rotate amounts, indexed by {round group, round[1:0]}
   localparam logic [4:0] ROT_AMOUNT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // One word on its way from the front to the back
   typedef struct packed {
      logic [31:0] word;
      logic        msg_end;
   } qword_type;

   // Queue fill status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Block word used by a given round
   function automatic logic [3:0] msg_index(input logic [5:0] rnd);
      logic [3:0] j;
      j = rnd[3:0];
      case (rnd[5:4])
         2'd0:    msg_index = j;
         2'd1:    msg_index = j * 4'd5 + 4'd1;
         2'd2:    msg_index = j * 4'd3 + 4'd5;
         2'd3:    msg_index = j * 4'd7;
         default: msg_index = j;
      endcase
   endfunction

   // Rotate left; amount is never zero
   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] amt);
      rotl32 = (x << amt) | (x >> (6'd32 - {1'b0, amt}));
   endfunction

endpackage

[rtl/core/md5_ifs.sv]
// Request and response channel interfaces of the MD5 digest engine.
interface md5_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic [2:0]  byte_count;
   logic        last;

   modport source (output valid, data_word, byte_count, last, input ready);
   modport sink (input valid, data_word, byte_count, last, output ready);
endinterface

interface md5_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_a;
   logic [31:0] digest_b;
   logic [31:0] digest_c;
   logic [31:0] digest_d;

   modport source (output valid, digest_a, digest_b, digest_c, digest_d, input ready);
   modport sink (input valid, digest_a, digest_b, digest_c, digest_d, output ready);
endinterface

[rtl/core/md5_front.sv]
// Front end: takes requests, tracks length and generates the padded word stream.
module md5_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [31:0]           data_word,
   input  logic [2:0]            byte_count,
   input  logic                  last,
   input  md5_pkg::q_status_type q_status,
   output logic                  push,
   output md5_pkg::qword_type    push_entry
);

   typedef enum logic [3:0] {
      F_DATA   = 4'b0001,
      F_PAD80  = 4'b0010,
      F_FILL   = 4'b0100,
      F_LEN_HI = 4'b1000
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [3:0]      pos_ff, pos_in;
   logic [63:0]     bit_len_ff, bit_len_in;
   logic [2:0]      cnt_sat;
   logic [31:0]     final_word;
   logic            req_take;

   assign req_ready = (state_ff == F_DATA) && !q_status.full;
   assign req_take  = req_valid && req_ready;

   // Final word: keep the valid bytes and, for a partial word, place the pad byte right after them
   always_comb begin
      cnt_sat = (byte_count > md5_pkg::FULL_WORD_BYTES) ? md5_pkg::FULL_WORD_BYTES : byte_count;
      case (cnt_sat)
         3'd0:    final_word = md5_pkg::PAD_BYTE;
         3'd1:    final_word = {16'h0000, 8'h80, data_word[7:0]};
         3'd2:    final_word = {8'h00, 8'h80, data_word[15:0]};
         3'd3:    final_word = {8'h80, data_word[23:0]};
         default: final_word = data_word;
      endcase
   end

   // Word generator
   always_comb begin
      state_in           = state_ff;
      bit_len_in         = bit_len_ff;
      push               = 1'b0;
      push_entry.word    = '0;
      push_entry.msg_end = 1'b0;
      unique case (state_ff)
         F_DATA: begin
            push = req_take;
            if (req_take) begin
               if (last) begin
                  push_entry.word = final_word;
                  bit_len_in      = bit_len_ff + 64'({cnt_sat, 3'b000});
                  state_in        = (cnt_sat == md5_pkg::FULL_WORD_BYTES) ? F_PAD80 : F_FILL;
               end else begin
                  push_entry.word = data_word;
                  bit_len_in      = bit_len_ff + md5_pkg::FULL_WORD_BITS;
               end
            end
         end
         F_PAD80: begin
            push            = !q_status.full;
            push_entry.word = md5_pkg::PAD_BYTE;
            if (push) begin
               state_in = F_FILL;
            end
         end
         F_FILL: begin
            push = !q_status.full;
            if (pos_ff == md5_pkg::LEN_LO_SLOT) begin
               push_entry.word = bit_len_ff[31:0];
               if (push) begin
                  state_in = F_LEN_HI;
               end
            end
         end
         F_LEN_HI: begin
            push               = !q_status.full;
            push_entry.word    = bit_len_ff[63:32];
            push_entry.msg_end = 1'b1;
            if (push) begin
               bit_len_in = '0;
               state_in   = F_DATA;
            end
         end
         default: begin
            state_in = F_DATA;
         end
      endcase
   end

   assign pos_in = push ? pos_ff + 4'd1 : pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_DATA;
         pos_ff     <= '0;
         bit_len_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         bit_len_ff <= bit_len_in;
      end
   end

endmodule

[rtl/core/md5_queue.sv]
// Four-entry word queue between the front end and the compression back end.
module md5_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  md5_pkg::qword_type    push_entry,
   input  logic                  pop,
   output md5_pkg::qword_type    pop_entry,
   output md5_pkg::q_status_type status
);

   localparam int DEPTH = 4;

   md5_pkg::qword_type entry_ff [DEPTH];
   logic [1:0]         wr_ptr_ff, wr_ptr_in;
   logic [1:0]         rd_ptr_ff, rd_ptr_in;
   logic [2:0]         count_ff, count_in;

   assign status.full  = (count_ff == 3'(DEPTH));
   assign status.empty = (count_ff == 3'd0);
   assign pop_entry    = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 3'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/core/md5_back.sv]
// Back end: block buffer, one-round-per-cycle compression and digest register.
module md5_back (
   input  logic                  clock,
   input  logic                  reset,
   input  md5_pkg::q_status_type q_status,
   input  md5_pkg::qword_type    pop_entry,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [31:0]           digest_a,
   output logic [31:0]           digest_b,
   output logic [31:0]           digest_c,
   output logic [31:0]           digest_d
);

   typedef enum logic [3:0] {
      B_LOAD = 4'b0001,
      B_PREP = 4'b0010,
      B_RUN  = 4'b0100,
      B_FOLD = 4'b1000
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [3:0]     load_cnt_ff, load_cnt_in;
   logic [5:0]     round_ff, round_in;
   logic           msg_end_ff, msg_end_in;
   logic [31:0]    chain_a_ff, chain_b_ff, chain_c_ff, chain_d_ff;
   logic [31:0]    chain_a_in, chain_b_in, chain_c_in, chain_d_in;
   logic [31:0]    work_a_ff, work_b_ff, work_c_ff, work_d_ff;
   logic [31:0]    work_a_in, work_b_in, work_c_in, work_d_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    dig_a_ff, dig_b_ff, dig_c_ff, dig_d_ff;
   logic           dig_load;
   logic [31:0]    block_mem [16];
   logic [31:0]    rd_word_ff;
   logic [3:0]     rd_addr;
   logic [31:0]    mix;
   logic [31:0]    round_sum;
   logic [31:0]    sum_a, sum_b, sum_c, sum_d;

   assign pop       = (state_ff == B_LOAD) && !q_status.empty;
   assign rsp_valid = rsp_valid_ff;
   assign digest_a  = dig_a_ff;
   assign digest_b  = dig_b_ff;
   assign digest_c  = dig_c_ff;
   assign digest_d  = dig_d_ff;

   // Block buffer: written while loading, read one word ahead while running
   assign rd_addr = (state_ff == B_PREP) ? md5_pkg::msg_index(6'd0)
                                         : md5_pkg::msg_index(round_ff + 6'd1);

   always_ff @(posedge clock) begin
      if (pop) begin
         block_mem[load_cnt_ff] <= pop_entry.word;
      end
      rd_word_ff <= block_mem[rd_addr];
   end

   // Round function
   always_comb begin
      case (round_ff[5:4])
         2'd0:    mix = (work_b_ff & work_c_ff) | (~work_b_ff & work_d_ff);
         2'd1:    mix = (work_d_ff & work_b_ff) | (~work_d_ff & work_c_ff);
         2'd2:    mix = work_b_ff ^ work_c_ff ^ work_d_ff;
         default: mix = work_c_ff ^ (work_b_ff | ~work_d_ff);
      endcase
      round_sum = work_a_ff + mix + md5_pkg::SINE_ADD[round_ff] + rd_word_ff;
   end

   assign sum_a = chain_a_ff + work_a_ff;
   assign sum_b = chain_b_ff + work_b_ff;
   assign sum_c = chain_c_ff + work_c_ff;
   assign sum_d = chain_d_ff + work_d_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      load_cnt_in  = load_cnt_ff;
      round_in     = round_ff;
      msg_end_in   = msg_end_ff;
      chain_a_in   = chain_a_ff;
      chain_b_in   = chain_b_ff;
      chain_c_in   = chain_c_ff;
      chain_d_in   = chain_d_ff;
      work_a_in    = work_a_ff;
      work_b_in    = work_b_ff;
      work_c_in    = work_c_ff;
      work_d_in    = work_d_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      dig_load     = 1'b0;
      unique case (state_ff)
         B_LOAD: begin
            if (pop) begin
               load_cnt_in = load_cnt_ff + 4'd1;
               if (load_cnt_ff == md5_pkg::LAST_SLOT) begin
                  msg_end_in = pop_entry.msg_end;
                  state_in   = B_PREP;
               end
            end
         end
         B_PREP: begin
            work_a_in = chain_a_ff;
            work_b_in = chain_b_ff;
            work_c_in = chain_c_ff;
            work_d_in = chain_d_ff;
            round_in  = '0;
            state_in  = B_RUN;
         end
         B_RUN: begin
            work_a_in = work_d_ff;
            work_d_in = work_c_ff;
            work_c_in = work_b_ff;
            work_b_in = work_b_ff + md5_pkg::rotl32(round_sum,
                           md5_pkg::ROT_AMOUNT[{round_ff[5:4], round_ff[1:0]}]);
            round_in  = round_ff + 6'd1;
            if (round_ff == md5_pkg::LAST_ROUND) begin
               state_in = B_FOLD;
            end
         end
         B_FOLD: begin
            if (!msg_end_ff) begin
               chain_a_in = sum_a;
               chain_b_in = sum_b;
               chain_c_in = sum_c;
               chain_d_in = sum_d;
               state_in   = B_LOAD;
            end else if (!rsp_valid_ff || rsp_ready) begin
               // Hand the digest over and start the next message from the IV
               dig_load     = 1'b1;
               rsp_valid_in = 1'b1;
               chain_a_in   = md5_pkg::INIT_A;
               chain_b_in   = md5_pkg::INIT_B;
               chain_c_in   = md5_pkg::INIT_C;
               chain_d_in   = md5_pkg::INIT_D;
               state_in     = B_LOAD;
            end
         end
         default: begin
            state_in = B_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_LOAD;
         load_cnt_ff  <= '0;
         round_ff     <= '0;
         msg_end_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         chain_a_ff   <= md5_pkg::INIT_A;
         chain_b_ff   <= md5_pkg::INIT_B;
         chain_c_ff   <= md5_pkg::INIT_C;
         chain_d_ff   <= md5_pkg::INIT_D;
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         round_ff     <= round_in;
         msg_end_ff   <= msg_end_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_a_ff   <= chain_a_in;
         chain_b_ff   <= chain_b_in;
         chain_c_ff   <= chain_c_in;
         chain_d_ff   <= chain_d_in;
      end
   end

   // Working words and digest payload
   always_ff @(posedge clock) begin
      work_a_ff <= work_a_in;
      work_b_ff <= work_b_in;
      work_c_ff <= work_c_in;
      work_d_ff <= work_d_in;
      if (dig_load) begin
         dig_a_ff <= sum_a;
         dig_b_ff <= sum_b;
         dig_c_ff <= sum_c;
         dig_d_ff <= sum_d;
      end
   end

endmodule

[rtl/core/md5_digest_engine_top.sv]
// Top level of the MD5 digest engine: front end, word queue and compression back end.
//
//   channel   dir   handshake             payload
//   req_bus   in    valid/ready           data_word[31:0], byte_count[2:0], last
//   rsp_bus   out   valid/ready           digest_a..digest_d[31:0]
//
// A taken request is pushed into the word queue in the same cycle; a final request adds 2 to 18 pad words.
// Each 16-word block is loaded, set up, run through 64 rounds and folded by the back end;
// sustained throughput is set by the compression unit, which does one round per cycle.
// Synchronous reset clears the sequencers, queue pointers and length and loads the IV chaining words; no clearing pass.
// Requests wait while the front emits pad words or the queue is full.
// A pending digest stalls the back only at its fold.
`include "md5_digest_engine_top_defines.svh"

module md5_digest_engine_top (
   input logic          clock,
   input logic          reset,
   md5_req_if.sink      req_bus,
   md5_rsp_if.source    rsp_bus
);

   md5_pkg::q_status_type q_status;
   md5_pkg::qword_type    push_entry;
   md5_pkg::qword_type    pop_entry;
   logic                  push;
   logic                  pop;

   md5_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .data_word  (req_bus.data_word),
      .byte_count (req_bus.byte_count),
      .last       (req_bus.last),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   md5_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   md5_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .digest_a  (rsp_bus.digest_a),
      .digest_b  (rsp_bus.digest_b),
      .digest_c  (rsp_bus.digest_c),
      .digest_d  (rsp_bus.digest_d)
   );

   // Queue is never overrun or underrun
   `MD5_ASSERT_IMPL(a_no_push_full, clock, reset, push, !q_status.full, "push into full queue")
   `MD5_ASSERT_IMPL(a_no_pop_empty, clock, reset, pop, !q_status.empty, "pop from empty queue")
   // A request is taken only as a queue push
   `MD5_ASSERT_IMPL(a_req_pushes, clock, reset, req_bus.valid && req_bus.ready, push, "request lost")
   // A pending digest is not replaced before it is taken
   `MD5_ASSERT_NEXT(a_rsp_kept, clock, reset, rsp_bus.valid && !rsp_bus.ready, rsp_bus.valid, "response dropped")

endmodule
